// ===== rtl/core/itc_pkg.sv =====
package itc_pkg;

	localparam int HDR_SUM_W = 21;	// at most 30 header words of 16 bits
	localparam int SEG_SUM_W = 32;	// whole segment plus pseudo-header

	localparam logic [7:0]  PROTO_TCP   = 8'd6;
	localparam logic [15:0] POS_MAX     = 16'hFFFF;
	localparam logic [15:0] ADDR_FIRST  = 16'd12;
	localparam logic [15:0] ADDR_LAST   = 16'd18;
	localparam logic [15:0] POS_IHL     = 16'd0;
	localparam logic [15:0] POS_LEN_LO  = 16'd3;
	localparam logic [15:0] POS_PROTO   = 16'd9;
	localparam logic [15:0] POS_ALWAYS  = 16'd4;

	// end-of-packet sums handed from the accumulator to the output stages
	typedef struct packed {
		logic [HDR_SUM_W-1:0] hdr_sum;
		logic [SEG_SUM_W-1:0] seg_sum;
		logic                 tcp;
	} itc_fin_t;

endpackage

// ===== rtl/core/ipv4_tcp_checksum.sv =====
// IPv4 header and TCP checksum, computed on the fly over a packet stream.
// Input channel (s_*): one packet byte per item, IPv4 header first with the
// Ethernet header already removed; s_tlast marks the final byte.
// Output channel (m_*): one item per packet, issued for its last byte.
// m_tdata carries the inverted, folded header checksum and TCP checksum;
// m_tuser is high when the protocol byte is 6, else the TCP field reads 0.
// Throughput: one byte per cycle, set by the accumulate step, unless stalled.
// Path: the last byte is held in the input register, its sums in the fold
// stage, and the folded checksums in the result register.
// Stall: the result register holds while m_tready is low; non-final bytes
// keep flowing, and only a final byte waits in the input register for the
// fold stage to free up, which then drops s_tready.
// Reset: arst_n clears all packet state and empties the pipeline; the next
// byte taken is byte 0 of a packet.
module ipv4_tcp_checksum
	import itc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,	// [7:0] data_byte
	input  logic        s_tlast,	// last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,	// [15:0] ip_header_checksum, [31:16] tcp_checksum
	output logic        m_tuser	// tcp_present
);

	function automatic logic [15:0] fold_inv(input logic [31:0] s);
		logic [16:0] f1;
		logic [15:0] f2;
		f1 = {1'b0, s[31:16]} + {1'b0, s[15:0]};
		f2 = f1[15:0] + {15'd0, f1[16]};
		return ~f2;
	endfunction

	// input register
	logic       valid_s1, last_s1;
	logic [7:0] data_s1;
	// fold stage
	logic       valid_s2;
	itc_fin_t   fin_s2;
	// result register
	logic        res_valid_q, res_tcp_q;
	logic [15:0] res_hdr_q, res_seg_q;

	logic     out_free, s2_free, s1_go;
	itc_fin_t fin;

	assign out_free = !res_valid_q || m_tready;
	assign s2_free  = !valid_s2 || out_free;
	// only a final byte needs room downstream
	assign s1_go    = valid_s1 && (!last_s1 || s2_free);
	assign s_tready = !valid_s1 || s1_go;

	itc_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (s1_go),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.fin       (fin)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (s2_free) begin
				valid_s2 <= s1_go && last_s1;
			end
			if (out_free) begin
				res_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
		if (s2_free && s1_go && last_s1) begin
			fin_s2 <= fin;
		end
		if (out_free && valid_s2) begin
			res_hdr_q <= fold_inv({{(32-HDR_SUM_W){1'b0}}, fin_s2.hdr_sum});
			res_seg_q <= fin_s2.tcp ? fold_inv(fin_s2.seg_sum) : 16'd0;
			res_tcp_q <= fin_s2.tcp;
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = {res_seg_q, res_hdr_q};
	assign m_tuser  = res_tcp_q;

	// a non-TCP packet reports a zero TCP checksum
	a_no_tcp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[31:16] == 16'd0)
		else $error("TCP checksum nonzero for non-TCP packet");

	// input back-pressure only comes from a final byte waiting for the fold stage
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && last_s1 && valid_s2 && res_valid_q && !m_tready)
		else $error("input stalled without a waiting final byte");

	// the fold stage fills only from a final byte
	a_fin_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1 && last_s1))
		else $error("fold stage loaded without a final byte");

endmodule

// ===== rtl/core/itc_accum.sv =====
module itc_accum
	import itc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output itc_fin_t   fin
);

	logic [15:0]          pos_q;
	logic [7:0]           pend_q;
	logic [HDR_SUM_W-1:0] hdr_q;
	logic [SEG_SUM_W-1:0] seg_q;
	logic [3:0]           ihl_q;
	logic [15:0]          plen_q;
	logic [7:0]           prot_q;

	logic                 in_rng, nxt_in_rng, odd, add_en, in_hdr, in_addr;
	logic [3:0]           ihl_n;
	logic [15:0]          plen_n, start, word, tcp_len;
	logic [7:0]           prot_n;
	logic [16:0]          seg_add;
	logic [HDR_SUM_W-1:0] hdr_n;
	logic [SEG_SUM_W-1:0] seg_n;

	always_comb begin
		odd        = pos_q[0];
		in_rng     = (pos_q < POS_ALWAYS) || (pos_q < plen_q);
		nxt_in_rng = ({1'b0, pos_q} + 17'd1 < {1'b0, POS_ALWAYS})
			|| ({1'b0, pos_q} + 17'd1 < {1'b0, plen_q});
		ihl_n  = (in_rng && pos_q == POS_IHL) ? data_byte[3:0] : ihl_q;
		plen_n = (in_rng && pos_q == POS_LEN_LO) ? {pend_q, data_byte} : plen_q;
		prot_n = (in_rng && pos_q == POS_PROTO) ? data_byte : prot_q;
		// a word is added on its low byte, or early on a high byte with no partner
		add_en = in_rng && (odd || last_byte || !nxt_in_rng);
		start  = {pos_q[15:1], 1'b0};
		word   = odd ? {pend_q, data_byte} : {data_byte, 8'h00};
		in_hdr  = start < {10'd0, ihl_n, 2'b00};
		in_addr = (start >= ADDR_FIRST) && (start <= ADDR_LAST);
		seg_add = 17'd0;
		if (add_en && !in_hdr) begin
			seg_add = seg_add + {1'b0, word};
		end
		if (add_en && in_addr) begin
			seg_add = seg_add + {1'b0, word};
		end
		hdr_n   = hdr_q + ((add_en && in_hdr) ? {{(HDR_SUM_W-16){1'b0}}, word} : '0);
		seg_n   = seg_q + {{(SEG_SUM_W-17){1'b0}}, seg_add};
		tcp_len = plen_n - {10'd0, ihl_n, 2'b00};
		fin.hdr_sum = hdr_n;
		fin.seg_sum = seg_n + {{(SEG_SUM_W-16){1'b0}}, tcp_len}
			+ {{(SEG_SUM_W-8){1'b0}}, PROTO_TCP};
		fin.tcp     = prot_n == PROTO_TCP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			pend_q <= '0;
			hdr_q  <= '0;
			seg_q  <= '0;
			ihl_q  <= '0;
			plen_q <= '0;
			prot_q <= '0;
		end else if (step) begin
			if (last_byte) begin
				// clear for the next packet
				pos_q  <= '0;
				pend_q <= '0;
				hdr_q  <= '0;
				seg_q  <= '0;
				ihl_q  <= '0;
				plen_q <= '0;
				prot_q <= '0;
			end else begin
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 16'd1;
				end
				if (in_rng && !odd) begin
					pend_q <= data_byte;
				end
				hdr_q  <= hdr_n;
				seg_q  <= seg_n;
				ihl_q  <= ihl_n;
				plen_q <= plen_n;
				prot_q <= prot_n;
			end
		end
	end

endmodule

// ===== dv/ipv4_tcp_checksum_check.sv =====
module ipv4_tcp_checksum_check
	import itc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,	// [7:0] data_byte
	input  logic        s_tlast,	// last_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,	// [15:0] ip_header_checksum, [31:16] tcp_checksum
	input  logic        m_tuser,	// tcp_present
	output int          failures,
	output int          waiting,
	output int          compared
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [15:0] hdr;
		logic [15:0] tcp;
		logic        present;
	} csum_t;

	// running packet state
	int unsigned pos = 0;
	logic [7:0]  hi_byte = '0;
	logic [31:0] hdr_acc = '0;
	logic [31:0] seg_acc = '0;
	logic [3:0]  ihl = '0;
	logic [15:0] total_len = '0;
	logic [7:0]  proto = '0;

	csum_t csum_q[$];
	csum_t want;

	task automatic clear_packet();
		pos = 0;
		hi_byte = '0;
		hdr_acc = '0;
		seg_acc = '0;
		ihl = '0;
		total_len = '0;
		proto = '0;
	endtask

	function automatic logic byte_wanted(input int unsigned p);
		return p < POS_ALWAYS || p < total_len;
	endfunction

	function automatic logic [15:0] fold_invert(input logic [31:0] s);
		logic [31:0] t;
		t = s;
		while (t[31:16] != 16'd0)
			t = {16'd0, t[31:16]} + {16'd0, t[15:0]};
		return ~t[15:0];
	endfunction

	// header words go to one sum, the rest to the other; addresses count twice
	task automatic credit_word(input int unsigned start, input logic [15:0] word);
		if (start < (32'(ihl) << 2))
			hdr_acc += {16'd0, word};
		else
			seg_acc += {16'd0, word};
		if (start >= ADDR_FIRST && start <= ADDR_LAST)
			seg_acc += {16'd0, word};
	endtask

	task automatic absorb_byte(input logic [7:0] b, input logic fin);
		int unsigned p;
		csum_t res;
		logic [15:0] tcp_len;
		p = pos;
		if (byte_wanted(p)) begin
			if (p == POS_IHL)
				ihl = b[3:0];
			if (p == POS_LEN_LO)
				total_len = {hi_byte, b};
			if (p == POS_PROTO)
				proto = b;
			if (!p[0]) begin
				hi_byte = b;
				if (fin || !byte_wanted(p + 1))
					credit_word(p, {b, 8'h00});
			end else begin
				credit_word(p - 1, {hi_byte, b});
			end
		end
		if (pos < POS_MAX)
			pos++;
		if (fin) begin
			tcp_len = total_len - {10'd0, ihl, 2'b00};
			res.hdr = fold_invert(hdr_acc);
			if (proto == PROTO_TCP) begin
				res.tcp = fold_invert(seg_acc + {24'd0, PROTO_TCP} + {16'd0, tcp_len});
				res.present = 1'b1;
			end else begin
				res.tcp = '0;
				res.present = 1'b0;
			end
			csum_q.push_back(res);
			clear_packet();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_packet();
			csum_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (csum_q.size() == 0) begin
					failures++;
					$error("result item with no packet pending: tdata %h tuser %b",
						m_tdata, m_tuser);
				end else begin
					want = csum_q.pop_front();
					compared++;
					if (m_tdata[15:0] !== want.hdr) begin
						failures++;
						$error("ip_header_checksum: expected %h, actual %h",
							want.hdr, m_tdata[15:0]);
					end
					if (m_tdata[31:16] !== want.tcp) begin
						failures++;
						$error("tcp_checksum: expected %h, actual %h",
							want.tcp, m_tdata[31:16]);
					end
					if (m_tuser !== want.present) begin
						failures++;
						$error("tcp_present: expected %b, actual %b",
							want.present, m_tuser);
					end
				end
			end
			if (s_tvalid && s_tready)
				absorb_byte(s_tdata, s_tlast);
		end
		waiting = csum_q.size();
	end

endmodule

// ===== dv/ipv4_tcp_checksum_test.sv =====
module ipv4_tcp_checksum_test
	import itc_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PHASE_BYTES = 540;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tuser;

	int failures;
	int waiting;
	int compared;

	// percentage of cycles in which each side holds back
	int src_idle = 0;
	int dst_idle = 0;

	int bytes_taken = 0;
	int frames_sent = 0;
	int cycles = 0;
	int phase_end;

	logic [7:0] frame[$];

	ipv4_tcp_checksum i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	ipv4_tcp_checksum_check i_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.failures (failures),
		.waiting  (waiting),
		.compared (compared)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: stop a hung run rather than let it spin forever.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Receiver: decide afresh on every falling edge whether to take a result.
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= dst_idle);

	// Offer one byte, with random idle cycles ahead of it, and hold it until
	// the block takes it. Returns on the falling edge after the handshake.
	task automatic push_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= fin;
		do @(posedge clk); while (!s_tready);
		bytes_taken++;
		@(negedge clk);
	endtask

	// Stream the assembled frame, flagging its final byte.
	task automatic send_frame();
		for (int i = 0; i < frame.size(); i++)
			push_byte(frame[i], i == frame.size() - 1);
		frames_sent++;
	endtask

	// Mostly well-formed IPv4 packets with random content; a share of them
	// carry a short header, a foreign protocol, a wild length field, spare
	// bytes past the total length, or are cut off early.
	task automatic build_random_frame();
		int pick;
		int ihl_v;
		int hdr_n;
		int pay_n;
		int cut;
		logic [15:0] total;
		logic [3:0] vers;
		pick = $urandom_range(99);
		if (pick < 60)
			ihl_v = 5;
		else if (pick < 90)
			ihl_v = $urandom_range(15, 6);
		else
			ihl_v = $urandom_range(4, 0);
		hdr_n = (ihl_v < 5) ? 20 : ihl_v * 4;
		pay_n = ($urandom_range(9) == 0) ? $urandom_range(120) : $urandom_range(30);
		frame.delete();
		for (int i = 0; i < hdr_n + pay_n; i++)
			frame.push_back(8'($urandom_range(255)));
		vers = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'd4;
		frame[0] = {vers, 4'(ihl_v)};
		if ($urandom_range(4) != 0)
			frame[9] = PROTO_TCP;
		total = 16'(frame.size());
		pick = $urandom_range(99);
		if (pick < 10)
			total = 16'($urandom_range(65535));
		frame[2] = total[15:8];
		frame[3] = total[7:0];
		// trailing bytes beyond the total length are ignored by the block
		if (pick >= 10 && pick < 25) begin
			repeat ($urandom_range(6, 1))
				frame.push_back(8'($urandom_range(255)));
		end
		// truncated packet: the last byte may arrive before the length says
		if (pick >= 25 && pick < 35) begin
			cut = $urandom_range(frame.size(), 1);
			while (frame.size() > cut)
				void'(frame.pop_back());
		end
	endtask

	initial begin
		// Hold reset, then release it away from the rising edge.
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: a lone all-ones byte, so the high byte alone makes a word.
		frame = '{8'hFF};
		send_frame();
		// Two-byte packet: one full word, length field never seen.
		frame = '{8'h00, 8'hFF};
		send_frame();
		// Largest IHL with a total length of three: bytes past it are dropped.
		frame = '{8'h4F, 8'hFF, 8'h00, 8'h03, 8'hAA, 8'h55};
		send_frame();
		// Short header, not TCP, cut off on an even position just before the addresses.
		frame = '{8'h40, 8'h00, 8'hFF, 8'hFF, 8'h12, 8'h34,
			8'h00, 8'h00, 8'h40, 8'h11, 8'hFF};
		send_frame();
		// Minimal TCP packet whose header is the whole of it.
		frame = '{8'h45, 8'h00, 8'h00, 8'h14, 8'h00, 8'h01, 8'h40, 8'h00};
		frame.push_back(8'h40);
		frame.push_back(PROTO_TCP);
		repeat (10) frame.push_back(8'($urandom_range(255)));
		send_frame();

		// Random traffic in three stall mixes: sender idles more lightly
		// than the receiver, then the other way round, then neither idles.
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					src_idle = 29;
					dst_idle = 57;
				end
				1: begin
					src_idle = 57;
					dst_idle = 29;
				end
				default: begin
					src_idle = 0;
					dst_idle = 0;
				end
			endcase
			phase_end = bytes_taken + PHASE_BYTES;
			while (bytes_taken < phase_end) begin
				build_random_frame();
				send_frame();
			end
			// Drain the block completely once before carrying on.
			if (ph == 0) begin
				s_tvalid <= 1'b0;
				while (waiting != 0)
					@(negedge clk);
			end
		end

		// Stop sending, then wait for every result.
		s_tvalid <= 1'b0;
		while (waiting != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		$display("Fed %0d bytes in %0d packets (directed and random)",
			bytes_taken, frames_sent);
		$display("Checked %0d checksum results across three sender/receiver stall mixes",
			compared);
		if (failures == 0 && waiting == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/itc_pkg.sv
rtl/core/itc_accum.sv
rtl/core/ipv4_tcp_checksum.sv
dv/ipv4_tcp_checksum_check.sv
dv/ipv4_tcp_checksum_test.sv
